FILE: hw/rtl/ksrq_pkg.sv
`default_nettype none

package ksrq_pkg;

  localparam int KEY_W    = 56;
  localparam int CODE_W   = 6;
  localparam int TIME_W   = 32;
  localparam int PEND_W   = 5;
  localparam int CMD_W    = 2;
  localparam int DATA_W   = 32;
  localparam int ADDR_W   = 5;
  localparam int REGIDX_W = 3;
  localparam int POS_W    = 6;
  localparam int GRP_W    = 3;

  localparam int QUEUE_DEPTH_DEF = 16;

  // last key position of the walk: group 7, bit 7
  localparam logic [POS_W-1:0] LAST_POS = POS_W'(KEY_W - 1);
  localparam logic [GRP_W-1:0] TOP_GRP  = GRP_W'(6);

  localparam logic [TIME_W-1:0] DELAY_RST  = TIME_W'(13107);
  localparam logic [TIME_W-1:0] PERIOD_RST = TIME_W'(2730);
  localparam logic [CODE_W-1:0] LOW_RST    = CODE_W'(1);
  localparam logic [CODE_W-1:0] HIGH_RST   = CODE_W'(4);
  localparam logic [CODE_W-1:0] EXTRA_RST  = CODE_W'(56);
  localparam logic [CODE_W-1:0] MAX_CODE   = CODE_W'(56);
  localparam logic [CODE_W-1:0] NO_CODE    = CODE_W'(0);

  typedef enum logic [CMD_W-1:0] {
    CMD_PRIME = 2'd0,
    CMD_SCAN  = 2'd1,
    CMD_POP   = 2'd2
  } cmd_e;

  typedef enum logic [REGIDX_W-1:0] {
    REG_DELAY  = 3'd0,
    REG_PERIOD = 3'd1,
    REG_LOW    = 3'd2,
    REG_HIGH   = 3'd3,
    REG_EXTRA  = 3'd4
  } reg_idx_e;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic step;
    logic check;
    logic pop_rd;
    logic pop_done;
    logic out_load;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic walk_last;
    logic fifo_empty;
  } dp_sts_t;

  // register write from the bus
  typedef struct packed {
    logic                en;
    logic [REGIDX_W-1:0] idx;
    logic [DATA_W-1:0]   data;
  } cfg_wr_t;

endpackage

`default_nettype wire

FILE: hw/rtl/ksrq_if.sv
`default_nettype none

interface ksrq_in_if;
  import ksrq_pkg::*;
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  cmd;
  logic [KEY_W-1:0]  key_state;
  logic [TIME_W-1:0] now;
  modport source (output valid, cmd, key_state, now, input ready);
  modport sink (input valid, cmd, key_state, now, output ready);
endinterface

interface ksrq_out_if;
  import ksrq_pkg::*;
  logic              valid;
  logic              ready;
  logic [CODE_W-1:0] key_code;
  logic [PEND_W-1:0] pending;
  modport source (output valid, key_code, pending, input ready);
  modport sink (input valid, key_code, pending, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/keypad_scan_repeat_queue.sv
`default_nettype none

// keypad scanner with typematic repeat and a key queue. each input transaction
// carries a command, a 7x8 key snapshot and a timestamp, and yields exactly one
// result transaction with the popped scan code (0 unless a pop finds a key) and
// the number of keys left in the queue. a scan walks the 56 newly-pressed bits
// one key per cycle, then makes the repeat check and loads the output register;
// a pop that finds a key passes through a ram read state and a write-back state
// because the queue ram has a registered read, and a pop of an empty queue, a
// prime or an unknown command goes straight to the output load.
// the next transaction is accepted the cycle after the result is registered;
// a result waits in the output register while the sink stalls, and a finished
// transaction holds there until the register frees. repeat timing uses
// modular 32-bit time differences. registers sit on an apb-style port at byte
// offsets 0x00 delay, 0x04 period, 0x08 range low, 0x0c range high, 0x10 extra
// code; write them only while the block is idle.
module keypad_scan_repeat_queue #(
  parameter int QUEUE_DEPTH = ksrq_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  ksrq_in_if.sink                            in_i,
  ksrq_out_if.source                         out_o,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [ksrq_pkg::ADDR_W-1:0]   paddr,
  input  wire logic [ksrq_pkg::DATA_W-1:0]   pwdata,
  output logic      [ksrq_pkg::DATA_W-1:0]   prdata,
  output logic                               pready
);
  import ksrq_pkg::*;

  ctrl_cmd_t ctrl_cmd;
  dp_sts_t   dp_sts;
  cfg_wr_t   cfg_wr;

  // apb decode: zero wait states, write lands in the access phase
  assign pready      = 1'b1;
  assign cfg_wr.en   = psel && penable && pwrite && pready;
  assign cfg_wr.idx  = paddr[ADDR_W-1:2];
  assign cfg_wr.data = pwdata;

  // sequencer: one transaction at a time, output register decoupled
  ksrq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .in_cmd_i    (in_i.cmd),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .cmd_o       (ctrl_cmd),
    .sts_i       (dp_sts)
  );

  // snapshot, key walk, repeat timer, queue ram and result register
  ksrq_dp #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (ctrl_cmd),
    .sts_o       (dp_sts),
    .in_cmd_i    (in_i.cmd),
    .in_keys_i   (in_i.key_state),
    .in_now_i    (in_i.now),
    .key_code_o  (out_o.key_code),
    .pending_o   (out_o.pending),
    .cfg_i       (cfg_wr),
    .cfg_rdata_o (prdata)
  );

endmodule

`default_nettype wire

FILE: hw/rtl/ksrq_ram.sv
`default_nettype none

module ksrq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: hw/rtl/ksrq_dp.sv
`default_nettype none

module ksrq_dp #(
  parameter int QUEUE_DEPTH = ksrq_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire ksrq_pkg::ctrl_cmd_t           cmd_i,
  output ksrq_pkg::dp_sts_t                  sts_o,
  input  wire logic [ksrq_pkg::CMD_W-1:0]    in_cmd_i,
  input  wire logic [ksrq_pkg::KEY_W-1:0]    in_keys_i,
  input  wire logic [ksrq_pkg::TIME_W-1:0]   in_now_i,
  output logic      [ksrq_pkg::CODE_W-1:0]   key_code_o,
  output logic      [ksrq_pkg::PEND_W-1:0]   pending_o,
  input  wire ksrq_pkg::cfg_wr_t             cfg_i,
  output logic      [ksrq_pkg::DATA_W-1:0]   cfg_rdata_o
);
  import ksrq_pkg::*;

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int SW = CW + 1;

  // configuration registers
  logic [TIME_W-1:0] delay_q, period_q;
  logic [CODE_W-1:0] low_q, high_q, extra_q;

  // scan state
  logic [KEY_W-1:0]  prev_q;
  logic [KEY_W-1:0]  pressed_q;
  logic [TIME_W-1:0] now_q;
  logic [POS_W-1:0]  pos_q;

  // queue state
  logic [PW-1:0]     head_q;
  logic [CW-1:0]     count_q, count_d;

  // repeat state
  logic [CODE_W-1:0] rep_code_q;
  logic [TIME_W-1:0] rep_start_q, rep_wait_q;

  // result payload
  logic [CODE_W-1:0] res_code_q;
  logic [CODE_W-1:0] out_code_q;
  logic [PEND_W-1:0] out_pend_q;

  logic [CODE_W-1:0] walk_code;
  logic              walk_hit, walk_rep;
  logic [CODE_W-1:0] rep_m1;
  logic [POS_W-1:0]  rep_pos;
  logic              rep_valid, rep_down, rep_due, rep_fire, rep_drop;
  logic [TIME_W-1:0] elapsed;
  logic              full;
  logic [SW-1:0]     tail_sum;
  logic [PW-1:0]     wr_addr;
  logic              wr_en;
  logic [CODE_W-1:0] wr_data;
  logic [CODE_W-1:0] rd_data;

  // scan code of the current walk position: (7-group)*8 + bit + 1
  assign walk_code = {TOP_GRP - pos_q[POS_W-1:3], pos_q[2:0]} + CODE_W'(1);
  assign walk_hit  = cmd_i.step && pressed_q[0];
  assign walk_rep  = ((walk_code >= low_q) && (walk_code <= high_q)) || (walk_code == extra_q);

  // key position of the armed code in the snapshot
  assign rep_m1    = rep_code_q - CODE_W'(1);
  assign rep_pos   = {TOP_GRP - rep_m1[CODE_W-1:3], rep_m1[2:0]};
  assign rep_valid = (rep_code_q != NO_CODE) && (rep_code_q <= MAX_CODE);
  assign rep_down  = rep_valid && prev_q[rep_pos];
  assign elapsed   = now_q - rep_start_q;
  assign rep_due   = elapsed >= rep_wait_q;
  assign rep_fire  = cmd_i.check && (rep_code_q != NO_CODE) && rep_down && rep_due;
  assign rep_drop  = cmd_i.check && (rep_code_q != NO_CODE) && !rep_down;

  assign full     = count_q == CW'(QUEUE_DEPTH);
  assign tail_sum = SW'(head_q) + SW'(count_q);
  assign wr_addr  = (tail_sum >= SW'(QUEUE_DEPTH)) ? PW'(tail_sum - SW'(QUEUE_DEPTH))
                                                  : PW'(tail_sum);
  assign wr_en    = (walk_hit || rep_fire) && !full;
  assign wr_data  = cmd_i.step ? walk_code : rep_code_q;

  always_comb begin
    count_d = count_q;
    if (wr_en) begin
      count_d = count_q + CW'(1);
    end else if (cmd_i.pop_done) begin
      count_d = count_q - CW'(1);
    end
  end

  ksrq_ram #(
    .WIDTH (CODE_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (wr_addr),
    .wdata_i (wr_data),
    .re_i    (cmd_i.pop_rd),
    .raddr_i (head_q),
    .rdata_o (rd_data)
  );

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delay_q  <= DELAY_RST;
      period_q <= PERIOD_RST;
      low_q    <= LOW_RST;
      high_q   <= HIGH_RST;
      extra_q  <= EXTRA_RST;
    end else if (cfg_i.en) begin
      case (cfg_i.idx)
        REG_DELAY:  delay_q  <= cfg_i.data;
        REG_PERIOD: period_q <= cfg_i.data;
        REG_LOW:    low_q    <= cfg_i.data[CODE_W-1:0];
        REG_HIGH:   high_q   <= cfg_i.data[CODE_W-1:0];
        REG_EXTRA:  extra_q  <= cfg_i.data[CODE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_i.idx)
      REG_DELAY:  cfg_rdata_o = delay_q;
      REG_PERIOD: cfg_rdata_o = period_q;
      REG_LOW:    cfg_rdata_o = DATA_W'(low_q);
      REG_HIGH:   cfg_rdata_o = DATA_W'(high_q);
      REG_EXTRA:  cfg_rdata_o = DATA_W'(extra_q);
      default:    cfg_rdata_o = '0;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q      <= '0;
      head_q      <= '0;
      count_q     <= '0;
      rep_code_q  <= NO_CODE;
      rep_start_q <= '0;
      rep_wait_q  <= '0;
      pos_q       <= '0;
    end else begin
      count_q <= count_d;
      if (cmd_i.load) begin
        if ((in_cmd_i == CMD_PRIME) || (in_cmd_i == CMD_SCAN)) begin
          prev_q <= in_keys_i;
        end
        pos_q <= '0;
      end else if (cmd_i.step) begin
        pos_q <= pos_q + POS_W'(1);
      end
      if (cmd_i.pop_done) begin
        head_q <= (head_q == PW'(QUEUE_DEPTH - 1)) ? '0 : head_q + PW'(1);
      end
      if (walk_hit && walk_rep) begin
        rep_code_q  <= walk_code;
        rep_start_q <= now_q;
        rep_wait_q  <= delay_q;
      end else if (rep_drop) begin
        rep_code_q <= NO_CODE;
      end else if (rep_fire) begin
        rep_start_q <= now_q;
        rep_wait_q  <= period_q;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      pressed_q  <= in_keys_i & ~prev_q;
      now_q      <= in_now_i;
      res_code_q <= NO_CODE;
    end else begin
      if (cmd_i.step) begin
        pressed_q <= pressed_q >> 1;
      end
      if (cmd_i.pop_done) begin
        res_code_q <= rd_data;
      end
    end
    if (cmd_i.out_load) begin
      out_code_q <= res_code_q;
      out_pend_q <= PEND_W'(count_q);
    end
  end

  assign sts_o.walk_last  = pos_q == LAST_POS;
  assign sts_o.fifo_empty = count_q == '0;
  assign key_code_o       = out_code_q;
  assign pending_o        = out_pend_q;

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(QUEUE_DEPTH))
    else $error("queue count above depth");

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.pop_done |-> count_q != '0)
    else $error("pop from empty queue");

  a_head_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_q <= PW'(QUEUE_DEPTH - 1))
    else $error("queue head out of range");
`endif

endmodule

`default_nettype wire

FILE: hw/rtl/ksrq_ctrl.sv
`default_nettype none

module ksrq_ctrl (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  output logic                            in_ready_o,
  input  wire logic [ksrq_pkg::CMD_W-1:0] in_cmd_i,
  output logic                            out_valid_o,
  input  wire logic                       out_ready_i,
  output ksrq_pkg::ctrl_cmd_t             cmd_o,
  input  wire ksrq_pkg::dp_sts_t          sts_i
);
  import ksrq_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WALK,
    ST_CHECK,
    ST_POP_RD,
    ST_POP_WB,
    ST_FINISH
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   accept, slot_free;

  assign in_ready_o = state_q == ST_IDLE;
  assign accept     = in_valid_i && in_ready_o;
  assign slot_free  = !out_valid_q || out_ready_i;

  always_comb begin
    state_d        = state_q;
    cmd_o          = '0;
    cmd_o.load     = accept;
    cmd_o.step     = state_q == ST_WALK;
    cmd_o.check    = state_q == ST_CHECK;
    cmd_o.pop_rd   = state_q == ST_POP_RD;
    cmd_o.pop_done = state_q == ST_POP_WB;
    cmd_o.out_load = (state_q == ST_FINISH) && slot_free;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (in_cmd_i)
            CMD_SCAN: state_d = ST_WALK;
            CMD_POP:  state_d = sts_i.fifo_empty ? ST_FINISH : ST_POP_RD;
            default:  state_d = ST_FINISH;
          endcase
        end
      end
      ST_WALK: begin
        if (sts_i.walk_last) begin
          state_d = ST_CHECK;
        end
      end
      ST_CHECK:  state_d = ST_FINISH;
      ST_POP_RD: state_d = ST_POP_WB;
      ST_POP_WB: state_d = ST_FINISH;
      ST_FINISH: begin
        if (slot_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

`ifndef NO_ASSERTIONS
  a_rise_from_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_FINISH))
    else $error("result shown without finishing");

  a_load_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> state_q != ST_IDLE)
    else $error("accepted transaction not processed");
`endif

endmodule

`default_nettype wire

FILE: test/tb.sv
`timescale 1ns / 100ps

module tb;
  import ksrq_pkg::*;

  // command code that the block must ignore
  localparam logic [CMD_W-1:0] CMD_BAD = 2'd3;
  localparam int FIFO_DEPTH = QUEUE_DEPTH_DEF;
  // cycles with no transaction on either side before the run is abandoned
  localparam int STALL_LIMIT = 20000;
  // length of the long receiver hold-off, long enough to back up the input
  localparam int HOLD_CYCLES = 400;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [KEY_W-1:0]  keys;
    logic [TIME_W-1:0] stamp;
  } snap_t;

  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic [PEND_W-1:0] pend;
  } key_result_t;

  logic clk_i;
  logic rst_ni;
  logic psel;
  logic penable;
  logic pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic pready;

  ksrq_in_if in_if ();
  ksrq_out_if out_if ();

  keypad_scan_repeat_queue dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_if),
    .out_o   (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // snapshots waiting to be sent, and results the block still owes us
  snap_t snap_q[$];
  key_result_t result_q[$];
  snap_t bus_snap;

  // traffic shaping, percent of cycles each side sits idle
  int send_idle;
  int recv_idle;
  logic hold_req;
  int hold_left;
  int stall_cycles;
  int err_cnt;

  // register shadow, mirrors what has been written over apb
  logic [TIME_W-1:0] cfg_delay = DELAY_RST;
  logic [TIME_W-1:0] cfg_period = PERIOD_RST;
  logic [CODE_W-1:0] cfg_low = LOW_RST;
  logic [CODE_W-1:0] cfg_high = HIGH_RST;
  logic [CODE_W-1:0] cfg_extra = EXTRA_RST;

  // predicted keypad state
  logic [KEY_W-1:0] last_keys;
  logic [CODE_W-1:0] code_fifo[FIFO_DEPTH];
  logic [3:0] fifo_rd;
  logic [PEND_W-1:0] fifo_used;
  logic [CODE_W-1:0] arm_code;
  logic [TIME_W-1:0] arm_start;
  logic [TIME_W-1:0] arm_wait;

  // stimulus-side view of the keypad and the clock it is read against
  logic [KEY_W-1:0] gen_keys;
  logic [TIME_W-1:0] gen_now;

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  // bit position of a scan code in the snapshot, code must be 1..56
  function automatic int key_pos(logic [CODE_W-1:0] code);
    int c;
    c = int'(code) - 1;
    return 8 * (6 - c / 8) + c % 8;
  endfunction

  function automatic bit repeatable(logic [CODE_W-1:0] code);
    return (code >= cfg_low && code <= cfg_high) || code == cfg_extra;
  endfunction

  // a full queue silently drops the key
  task automatic push_code(logic [CODE_W-1:0] code);
    if (fifo_used < PEND_W'(FIFO_DEPTH)) begin
      code_fifo[4'(fifo_rd + fifo_used)] = code;
      fifo_used++;
    end
  endtask

  task automatic keypad_scan(logic [KEY_W-1:0] keys, logic [TIME_W-1:0] stamp);
    logic [KEY_W-1:0] fresh;
    logic [CODE_W-1:0] code;
    logic [TIME_W-1:0] waited;
    fresh = keys & ~last_keys;
    last_keys = keys;
    // walk group 1 bit 0 up to group 7 bit 7, last repeatable press wins
    for (int p = 0; p < KEY_W; p++) begin
      if (fresh[p]) begin
        code = CODE_W'((6 - p / 8) * 8 + p % 8 + 1);
        push_code(code);
        if (repeatable(code)) begin
          arm_code = code;
          arm_start = stamp;
          arm_wait = cfg_delay;
        end
      end
    end
    // repeat check, also covers a key armed in this very scan
    waited = stamp - arm_start;
    if (arm_code != NO_CODE && !last_keys[key_pos(arm_code)]) begin
      arm_code = NO_CODE;
    end else if (arm_code != NO_CODE && waited >= arm_wait) begin
      push_code(arm_code);
      arm_start = stamp;
      arm_wait = cfg_period;
    end
  endtask

  // one snapshot transaction in, one result out
  task automatic keypad_step(snap_t s);
    key_result_t r;
    r.code = NO_CODE;
    case (s.cmd)
      CMD_PRIME: begin
        last_keys = s.keys;
      end
      CMD_SCAN: begin
        keypad_scan(s.keys, s.stamp);
      end
      CMD_POP: begin
        if (fifo_used != 0) begin
          r.code = code_fifo[fifo_rd];
          fifo_rd++;
          fifo_used--;
        end
      end
      default: begin
      end
    endcase
    r.pend = fifo_used;
    result_q.push_back(r);
  endtask

  task automatic flag_mismatch(string what);
    err_cnt++;
    if (err_cnt <= 50) $display("mismatch at %0t: %s", $time, what);
  endtask

  // ---------------------------------------------------------------------------
  // clock and initial pin values
  // ---------------------------------------------------------------------------

  initial begin
    clk_i = 1'b0;
    rst_ni = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_if.valid = 1'b0;
    in_if.cmd = CMD_PRIME;
    in_if.key_state = '0;
    in_if.now = '0;
    out_if.ready = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // driver: takes snapshots off the queue, predicts on each accepted transaction
  // ---------------------------------------------------------------------------

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
    end else begin
      if (in_if.valid && in_if.ready) keypad_step(bus_snap);
      // valid holds until accepted, a new transaction may follow back to back
      if (!in_if.valid || in_if.ready) begin
        if (snap_q.size() > 0 && $urandom_range(99) >= send_idle) begin
          bus_snap = snap_q.pop_front();
          in_if.valid <= 1'b1;
          in_if.cmd <= bus_snap.cmd;
          in_if.key_state <= bus_snap.keys;
          in_if.now <= bus_snap.stamp;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: checks each result transaction and paces ready
  // ---------------------------------------------------------------------------

  always @(posedge clk_i) begin
    key_result_t want;
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (result_q.size() == 0) begin
          flag_mismatch($sformatf("unexpected result code %0d pending %0d",
                                  out_if.key_code, out_if.pending));
        end else begin
          want = result_q.pop_front();
          if (out_if.key_code !== want.code)
            flag_mismatch($sformatf("key_code %0d, predicted %0d", out_if.key_code,
                                    want.code));
          if (out_if.pending !== want.pend)
            flag_mismatch($sformatf("pending %0d, predicted %0d", out_if.pending,
                                    want.pend));
        end
      end
      // long hold-off so the block fills up and stalls its input
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req <= 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= ($urandom_range(99) >= recv_idle);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // watchdog: cycles with no transaction on either channel
  // ---------------------------------------------------------------------------

  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("timeout after %0d idle cycles", stall_cycles);
      $display("Simulation FAILED");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------

  function automatic logic [KEY_W-1:0] rand_keys();
    return KEY_W'({$urandom(), $urandom()});
  endfunction

  task automatic queue_snap(logic [CMD_W-1:0] cmd, logic [KEY_W-1:0] keys,
                            logic [TIME_W-1:0] stamp);
    snap_t s;
    s.cmd = cmd;
    s.keys = keys;
    s.stamp = stamp;
    snap_q.push_back(s);
  endtask

  // apb write: setup cycle, then access cycle, register loads at the end of it
  task automatic write_reg(reg_idx_e idx, logic [DATA_W-1:0] val);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_DELAY:  cfg_delay = val;
      REG_PERIOD: cfg_period = val;
      REG_LOW:    cfg_low = CODE_W'(val);
      REG_HIGH:   cfg_high = CODE_W'(val);
      REG_EXTRA:  cfg_extra = CODE_W'(val);
      default: begin
      end
    endcase
  endtask

  task automatic set_regs(logic [TIME_W-1:0] delay, logic [TIME_W-1:0] period,
                          int lo, int hi, int extra);
    write_reg(REG_DELAY, delay);
    write_reg(REG_PERIOD, period);
    write_reg(REG_LOW, DATA_W'(lo));
    write_reg(REG_HIGH, DATA_W'(hi));
    write_reg(REG_EXTRA, DATA_W'(extra));
  endtask

  // block is idle once nothing is queued, on the bus or owed
  task automatic wait_drained();
    while (snap_q.size() > 0 || in_if.valid || result_q.size() > 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // mostly plausible keypad activity: held keys, presses of repeatable keys,
  // time steps around the delay and period, plus pops, primes and junk commands
  task automatic queue_random(int n);
    int sel;
    int code;
    for (int i = 0; i < n; i++) begin
      sel = $urandom_range(99);
      if (sel < 30) begin
        queue_snap(CMD_POP, rand_keys(), $urandom());
      end else if (sel < 36) begin
        if ($urandom_range(1) == 1) gen_keys = rand_keys();
        queue_snap(CMD_PRIME, gen_keys, $urandom());
      end else if (sel < 39) begin
        queue_snap(CMD_BAD, rand_keys(), $urandom());
      end else begin
        sel = $urandom_range(99);
        if (sel < 45) begin
          if (cfg_low <= cfg_high && $urandom_range(3) != 0)
            code = $urandom_range(cfg_low, cfg_high);
          else
            code = cfg_extra;
          gen_keys[key_pos(CODE_W'(code))] ^= 1'b1;
        end else if (sel < 75) begin
          gen_keys[$urandom_range(KEY_W - 1)] ^= 1'b1;
        end else if (sel < 85) begin
          // keys held as they are
        end else if (sel < 93) begin
          gen_keys = rand_keys();
        end else begin
          gen_keys = ($urandom_range(1) == 1) ? '1 : '0;
        end
        sel = $urandom_range(99);
        if (sel < 20) begin
          // same timestamp
        end else if (sel < 45) begin
          gen_now += $urandom_range(1, 200);
        end else if (sel < 65) begin
          gen_now += cfg_delay - 1 + $urandom_range(0, 2);
        end else if (sel < 85) begin
          gen_now += cfg_period - 1 + $urandom_range(0, 2);
        end else begin
          gen_now = $urandom();
        end
        queue_snap(CMD_SCAN, gen_keys, gen_now);
      end
    end
  endtask

  initial begin
    int lo;
    last_keys = '0;
    fifo_rd = '0;
    fifo_used = '0;
    arm_code = NO_CODE;
    arm_start = '0;
    arm_wait = '0;
    gen_keys = '0;
    gen_now = '0;
    hold_req = 1'b0;
    hold_left = 0;
    stall_cycles = 0;
    err_cnt = 0;
    send_idle = 32;
    recv_idle = 75;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part at reset register values: full queue, dropped keys,
    // dropped repeat, period boundary, release disarm, empty pops
    queue_snap(CMD_PRIME, '0, '0);
    queue_snap(CMD_SCAN, '1, '0);
    queue_snap(CMD_BAD, '1, '1);
    queue_snap(CMD_SCAN, '1, 32'd13107);
    queue_snap(CMD_POP, '1, '1);
    queue_snap(CMD_SCAN, '1, 32'd15836);
    queue_snap(CMD_SCAN, '1, 32'd15837);
    queue_snap(CMD_SCAN, '0, 32'hffff_ffff);
    repeat (17) queue_snap(CMD_POP, rand_keys(), $urandom());
    wait_drained();

    // first random stretch with the receiver holding off
    queue_random(100);
    @(posedge clk_i);
    hold_req <= 1'b1;
    wait_drained();
    queue_random(100);
    wait_drained();

    for (int phase = 1; phase <= 5; phase++) begin
      send_idle = (phase <= 1) ? 32 : (phase <= 3) ? 75 : 0;
      recv_idle = (phase <= 1) ? 75 : (phase <= 3) ? 32 : 0;
      case (phase)
        1: set_regs('0, '0, 1, 56, 56);                  // everything repeats at once
        2: begin                                         // empty range, longest waits
          set_regs('1, '1, 56, 1, 1);
          gen_now = 32'hffff_ff00;
        end
        3: begin
          lo = $urandom_range(1, 56);
          set_regs($urandom_range(0, 3000), $urandom_range(0, 1000), lo,
                   $urandom_range(lo, 56), $urandom_range(1, 56));
        end
        4: begin                                         // single-code range
          lo = $urandom_range(1, 56);
          set_regs(32'd1, 32'h8000_0000, lo, lo, 56);
        end
        default: begin
          lo = $urandom_range(1, 56);
          set_regs($urandom_range(0, 500), $urandom_range(1, 300), lo,
                   $urandom_range(1, 56), $urandom_range(1, 56));
        end
      endcase
      queue_random(100);
      if (phase == 4) begin
        @(posedge clk_i);
        hold_req <= 1'b1;
      end
      // sender pauses here until the block has delivered everything
      wait_drained();
      queue_random(100);
      wait_drained();
    end

    repeat (64) @(posedge clk_i);
    if (result_q.size() > 0)
      flag_mismatch($sformatf("%0d results never arrived", result_q.size()));
    if (err_cnt == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
